// File: sv/lfd_pkg.sv
// ----------------------------------------------------------------------------
// lfd_pkg
// Shared types and constants of the length-encoded field decoder.
// ----------------------------------------------------------------------------
package lfd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned KIND_W      = 3;
    localparam int unsigned ERR_W       = 2;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 72;
    localparam int unsigned LANES       = VALUE_W / BYTE_W;

    localparam logic [BYTE_W-1:0] PFX_NULL     = 8'hFB;
    localparam logic [BYTE_W-1:0] PFX_LEN2     = 8'hFC;
    localparam logic [BYTE_W-1:0] PFX_LEN3     = 8'hFD;
    localparam logic [BYTE_W-1:0] PFX_LEN8     = 8'hFE;
    localparam logic [BYTE_W-1:0] PFX_RESERVED = 8'hFF;

    localparam logic [3:0] LEN2_BYTES = 4'd2;
    localparam logic [3:0] LEN3_BYTES = 4'd3;
    localparam logic [3:0] LEN8_BYTES = 4'd8;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PREFIX  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_INT   = 3'd0,
        KIND_BYTE  = 3'd1,
        KIND_NULL  = 3'd2,
        KIND_EMPTY = 3'd3,
        KIND_ERR   = 3'd4
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_RESERVED = 2'd1,
        ERR_TRUNC    = 2'd2,
        ERR_OVERRUN  = 2'd3
    } t_err;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_in_item;

endpackage

// File: sv/lfd_in_reg.sv
// ----------------------------------------------------------------------------
// lfd_in_reg
// Input register: captures one raw byte and its buffer-end flag per transaction.
// ----------------------------------------------------------------------------
module lfd_in_reg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [lfd_pkg::BYTE_W-1:0] s_axis_tdata,
    input  logic                      s_axis_tlast,
    input  logic                      i_advance,
    output lfd_pkg::t_in_item         o_item
);

    lfd_pkg::t_in_item r_item;

    assign s_axis_tready = !r_item.valid || i_advance;
    assign o_item        = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_item.valid <= s_axis_tvalid;
            end
            if (s_axis_tready && s_axis_tvalid) begin
                r_item.data <= s_axis_tdata;
                r_item.last <= s_axis_tlast;
            end
        end
    end

endmodule

// File: sv/lfd_decoder.sv
// ----------------------------------------------------------------------------
// lfd_decoder
// Field state, mode register, single-pass decode and the result register.
// ----------------------------------------------------------------------------
module lfd_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_data,
    output logic                           o_cfg_ready,
    input  lfd_pkg::t_in_item              i_item,
    output logic                           o_advance,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [lfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [lfd_pkg::KIND_W-1:0]     m_axis_tuser,
    output logic                           m_axis_tlast
);

    logic                           r_field_mode;
    lfd_pkg::t_phase                r_phase, n_phase;
    logic [3:0]                     r_pfx_left, n_pfx_left;
    logic [2:0]                     r_byte_pos, n_byte_pos;
    logic [lfd_pkg::VALUE_W-1:0]    r_acc, n_acc;
    logic [lfd_pkg::VALUE_W-1:0]    r_pay_left, n_pay_left;

    logic                           r_out_valid;
    lfd_pkg::t_kind                 r_kind;
    logic [lfd_pkg::VALUE_W-1:0]    r_value;
    lfd_pkg::t_err                  r_err;
    logic                           r_last;

    logic                           n_res_valid;
    lfd_pkg::t_kind                 n_kind;
    logic [lfd_pkg::VALUE_W-1:0]    n_value;
    lfd_pkg::t_err                  n_err;
    logic                           n_last;

    logic                           fin;
    logic [lfd_pkg::VALUE_W-1:0]    fin_val;
    logic [lfd_pkg::VALUE_W-1:0]    acc_ins;
    logic [3:0]                     pfx_dec;
    logic [lfd_pkg::BYTE_W-1:0]     b;
    logic                           b_end;

    assign o_cfg_ready = 1'b1;
    assign o_advance   = !r_out_valid || m_axis_tready;
    assign b           = i_item.data;
    assign b_end       = i_item.last;

    always_comb begin
        acc_ins = r_acc;
        for (int i = 0; i < lfd_pkg::LANES; i++) begin
            if (r_byte_pos == 3'(i)) begin
                acc_ins[i*lfd_pkg::BYTE_W +: lfd_pkg::BYTE_W] =
                    r_acc[i*lfd_pkg::BYTE_W +: lfd_pkg::BYTE_W] | b;
            end
        end
    end

    assign pfx_dec = r_pfx_left - 4'd1;

    always_comb begin
        n_phase     = r_phase;
        n_pfx_left  = r_pfx_left;
        n_byte_pos  = r_byte_pos;
        n_acc       = r_acc;
        n_pay_left  = r_pay_left;
        n_res_valid = 1'b0;
        n_kind      = lfd_pkg::KIND_INT;
        n_value     = '0;
        n_err       = lfd_pkg::ERR_NONE;
        n_last      = 1'b1;
        fin         = 1'b0;
        fin_val     = '0;

        unique case (r_phase)
            lfd_pkg::PH_PREFIX: begin
                n_acc      = acc_ins;
                n_byte_pos = r_byte_pos + 3'd1;
                n_pfx_left = pfx_dec;
                if (pfx_dec == 4'd0) begin
                    fin     = 1'b1;
                    fin_val = acc_ins;
                end else if (b_end) begin
                    n_phase     = lfd_pkg::PH_IDLE;
                    n_pfx_left  = '0;
                    n_byte_pos  = '0;
                    n_acc       = '0;
                    n_res_valid = 1'b1;
                    n_kind      = lfd_pkg::KIND_ERR;
                    n_err       = lfd_pkg::ERR_TRUNC;
                end
            end
            lfd_pkg::PH_PAYLOAD: begin
                n_res_valid = 1'b1;
                if (r_pay_left <= lfd_pkg::VALUE_W'(1)) begin
                    n_phase    = lfd_pkg::PH_IDLE;
                    n_pay_left = '0;
                    n_kind     = lfd_pkg::KIND_BYTE;
                    n_value    = lfd_pkg::VALUE_W'(b);
                end else if (b_end) begin
                    n_phase    = lfd_pkg::PH_IDLE;
                    n_pay_left = '0;
                    n_kind     = lfd_pkg::KIND_ERR;
                    n_err      = lfd_pkg::ERR_OVERRUN;
                end else begin
                    n_pay_left = r_pay_left - lfd_pkg::VALUE_W'(1);
                    n_kind     = lfd_pkg::KIND_BYTE;
                    n_value    = lfd_pkg::VALUE_W'(b);
                    n_last     = 1'b0;
                end
            end
            default: begin
                n_phase    = lfd_pkg::PH_IDLE;
                n_pfx_left = '0;
                n_byte_pos = '0;
                n_acc      = '0;
                n_pay_left = '0;
                if (b < lfd_pkg::PFX_NULL) begin
                    fin     = 1'b1;
                    fin_val = lfd_pkg::VALUE_W'(b);
                end else if (b == lfd_pkg::PFX_NULL) begin
                    n_res_valid = 1'b1;
                    n_kind      = lfd_pkg::KIND_NULL;
                end else if (b == lfd_pkg::PFX_RESERVED) begin
                    n_res_valid = 1'b1;
                    n_kind      = lfd_pkg::KIND_ERR;
                    n_err       = lfd_pkg::ERR_RESERVED;
                end else if (b_end) begin
                    n_res_valid = 1'b1;
                    n_kind      = lfd_pkg::KIND_ERR;
                    n_err       = lfd_pkg::ERR_TRUNC;
                end else begin
                    n_phase = lfd_pkg::PH_PREFIX;
                    if (b == lfd_pkg::PFX_LEN2) begin
                        n_pfx_left = lfd_pkg::LEN2_BYTES;
                    end else if (b == lfd_pkg::PFX_LEN3) begin
                        n_pfx_left = lfd_pkg::LEN3_BYTES;
                    end else begin
                        n_pfx_left = lfd_pkg::LEN8_BYTES;
                    end
                end
            end
        endcase

        if (fin) begin
            n_phase    = lfd_pkg::PH_IDLE;
            n_pfx_left = '0;
            n_byte_pos = '0;
            n_acc      = '0;
            n_pay_left = '0;
            if (!r_field_mode) begin
                n_res_valid = 1'b1;
                n_kind      = lfd_pkg::KIND_INT;
                n_value     = fin_val;
            end else if (fin_val == '0) begin
                n_res_valid = 1'b1;
                n_kind      = lfd_pkg::KIND_EMPTY;
            end else if (b_end) begin
                n_res_valid = 1'b1;
                n_kind      = lfd_pkg::KIND_ERR;
                n_err       = lfd_pkg::ERR_OVERRUN;
            end else begin
                n_phase    = lfd_pkg::PH_PAYLOAD;
                n_pay_left = fin_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_field_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lfd_pkg::PH_IDLE;
            r_pfx_left  <= '0;
            r_byte_pos  <= '0;
            r_acc       <= '0;
            r_pay_left  <= '0;
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_item.valid && n_res_valid;
            if (i_item.valid) begin
                r_phase    <= n_phase;
                r_pfx_left <= n_pfx_left;
                r_byte_pos <= n_byte_pos;
                r_acc      <= n_acc;
                r_pay_left <= n_pay_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_item.valid && n_res_valid) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_err   <= n_err;
            r_last  <= n_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_err, r_value};
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;

endmodule

// File: sv/lenenc_field_decoder_unit.sv
// ----------------------------------------------------------------------------
// lenenc_field_decoder_unit
// Length-encoded integer and string decoder, one byte per transaction.
// ----------------------------------------------------------------------------
// The block takes one raw byte per cycle while the output is not stalled and gives at most
// one result per byte: the byte is held in the input register, and its result is registered
// in the result register. The rate of one byte per cycle is set by the single decode stage
// between the input register and the result register, which updates the 64-bit accumulator
// and payload counter in one step. The mode register selects integer or string decoding and
// is sampled on the byte that completes a length; it should be written only while the stream
// is idle. After an error result the consumer discards any payload bytes already delivered
// for that field.
module lenenc_field_decoder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_data,    // field_mode
    output logic                            o_cfg_ready,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lfd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic                            s_axis_tlast,  // buffer_end
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [63:0] result_value, [65:64] error_code
    output logic [lfd_pkg::KIND_W-1:0]      m_axis_tuser,  // [2:0] result_kind
    output logic                            m_axis_tlast   // field_last
);

    lfd_pkg::t_in_item item;
    logic              advance;

    lfd_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_advance     (advance),
        .o_item        (item)
    );

    lfd_decoder u_decoder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready),
        .i_item        (item),
        .o_advance     (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: sv/lfd_checker.sv
// ----------------------------------------------------------------------------
// lfd_checker
// Port-level checks of the decoder's result stream.
// ----------------------------------------------------------------------------
module lfd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [lfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [lfd_pkg::KIND_W-1:0]      m_axis_tuser,
    input logic                            m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("Stalled result transaction changed.");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((m_axis_tuser == lfd_pkg::KIND_ERR) == (m_axis_tdata[65:64] != lfd_pkg::ERR_NONE)))
        else $error("Error code does not match the result kind.");

    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == lfd_pkg::KIND_ERR
            || m_axis_tuser == lfd_pkg::KIND_NULL || m_axis_tuser == lfd_pkg::KIND_EMPTY)
            |-> m_axis_tdata[63:0] == '0)
        else $error("Value not zero on a result that carries none.");

    a_byte_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == lfd_pkg::KIND_BYTE |-> m_axis_tdata[63:8] == '0)
        else $error("Payload byte wider than eight bits.");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != lfd_pkg::KIND_BYTE |-> m_axis_tlast)
        else $error("Non-payload result does not complete its field.");

endmodule

bind lenenc_field_decoder_unit lfd_checker u_lfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
